/* hw/rtl/csprb_pkg.sv */
// csprb_pkg: shared types, codes and constants of the CSP channel buffer.
// No dependencies.
package csprb_pkg;

  localparam int SLOTS_DEFAULT = 4;
  localparam int CAP_RESET     = 4;
  localparam int CMD_W         = 2;
  localparam int ID_W          = 8;
  localparam int DATA_W        = 32;
  localparam int RSP_W         = 3;
  localparam int CFG_W         = 3;
  localparam int MAX_RES       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_POISON = 2'd2
  } cmd_t;

  typedef enum logic [RSP_W-1:0] {
    RSP_READ      = 3'd0,
    RSP_WRITE     = 3'd1,
    RSP_POISONED  = 3'd2,
    RSP_NACK      = 3'd3,
    RSP_POISON_OK = 3'd4
  } rsp_t;

  // One pending write in the channel buffer.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] size;
  } entry_t;

  // One completion word waiting for the result channel.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    rsp_t              rsp;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] size;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic pop;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] eval_cnt;
    logic [1:0] pending;
  } dp_stat_t;

endpackage

/* hw/rtl/csprb_ifs.sv */
// csprb_ifs: valid/ready channel interfaces for request and completion words.
// Depends on csprb_pkg.
interface csprb_req_if;
  import csprb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ID_W-1:0]     request_id;
  logic [DATA_W-1:0]   data_address;
  logic [DATA_W-1:0]   data_size;

  modport source (output valid, command, request_id, data_address, data_size,
                  input ready);
  modport sink   (input valid, command, request_id, data_address, data_size,
                  output ready);
endinterface

interface csprb_rsp_if;
  import csprb_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     done_id;
  logic [RSP_W-1:0]    response;
  logic [DATA_W-1:0]   read_address;
  logic [DATA_W-1:0]   read_size;
  logic                last;

  modport source (output valid, done_id, response, read_address, read_size, last,
                  input ready);
  modport sink   (input valid, done_id, response, read_address, read_size, last,
                  output ready);
endinterface

/* hw/rtl/csprb_ctrl.sv */
// csprb_ctrl: sequencer of the channel buffer (capture, evaluate, emit).
// Depends on csprb_pkg.
module csprb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csprb_pkg::dp_cmd_t  cmd,
  input  csprb_pkg::dp_stat_t stat
);
  import csprb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        // a read that parks or a write that is held completes nothing yet
        state_nxt = (stat.eval_cnt == 2'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (stat.pending == 2'd1) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hw/rtl/csprb_dp.sv */
// csprb_dp: channel state, pending-write memory and completion buffer.
// Depends on csprb_pkg; driven by csprb_ctrl.
module csprb_dp #(
  parameter int SLOTS = csprb_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csprb_pkg::dp_cmd_t                cmd,
  output csprb_pkg::dp_stat_t               stat,
  input  logic [csprb_pkg::CMD_W-1:0]       in_command,
  input  logic [csprb_pkg::ID_W-1:0]        in_request_id,
  input  logic [csprb_pkg::DATA_W-1:0]      in_data_address,
  input  logic [csprb_pkg::DATA_W-1:0]      in_data_size,
  input  logic                              cfg_we,
  input  logic [csprb_pkg::CFG_W-1:0]       cfg_wdata,
  output logic [csprb_pkg::ID_W-1:0]        out_done_id,
  output logic [csprb_pkg::RSP_W-1:0]       out_response,
  output logic [csprb_pkg::DATA_W-1:0]      out_read_address,
  output logic [csprb_pkg::DATA_W-1:0]      out_read_size,
  output logic                              out_last
);
  import csprb_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CFG_W-1:0] SLOTS_RST =
      (SLOTS > CAP_RESET) ? CFG_W'(CAP_RESET) : CFG_W'(SLOTS);

  // state
  logic [CFG_W-1:0]  slots_r;
  logic [IW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              rdw_r, rdw_nxt;
  logic [ID_W-1:0]   rdid_r, rdid_nxt;
  logic              poison_r, poison_nxt;
  entry_t            mem [SLOTS];

  // captured request and memory read data
  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [DATA_W-1:0] addr_q;
  logic [DATA_W-1:0] size_q;
  entry_t            head_q;
  entry_t            tail_q;

  // completion buffer
  result_t           res_r [MAX_RES];
  result_t           res_nxt [MAX_RES];
  logic [1:0]        pend_r;
  logic [1:0]        n;

  logic [CW-1:0]     cap;
  logic [CW:0]       wr_sum, tl_sum;
  logic [IW-1:0]     wr_slot, tl_slot;
  logic              mem_we;

  function automatic result_t mk(input logic [ID_W-1:0] id, input rsp_t rsp,
                                 input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] s);
    result_t r;
    r.id   = id;
    r.rsp  = rsp;
    r.addr = a;
    r.size = s;
    return r;
  endfunction

  // capacity clamped to 1..SLOTS
  always_comb begin
    if (slots_r == '0)                cap = CW'(1);
    else if (int'(slots_r) > SLOTS)   cap = CW'(SLOTS);
    else                              cap = CW'(slots_r);
  end

  // ring addresses: tail-in slot and last occupied slot
  always_comb begin
    wr_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (wr_sum >= (CW+1)'(SLOTS)) wr_sum = wr_sum - (CW+1)'(SLOTS);
    wr_slot = wr_sum[IW-1:0];
    if (count_r == '0) tl_sum = (CW+1)'(head_r);
    else               tl_sum = (CW+1)'(head_r) + (CW+1)'(count_r) - (CW+1)'(1);
    if (tl_sum >= (CW+1)'(SLOTS)) tl_sum = tl_sum - (CW+1)'(SLOTS);
    tl_slot = tl_sum[IW-1:0];
  end

  // evaluation of the captured request
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rdw_nxt    = rdw_r;
    rdid_nxt   = rdid_r;
    poison_nxt = poison_r;
    mem_we     = 1'b0;
    n          = 2'd0;
    for (int i = 0; i < MAX_RES; i++) res_nxt[i] = '0;
    unique case (cmd_q)
      CMD_WRITE: begin
        if (count_r >= cap) begin
          res_nxt[n] = mk(id_q, RSP_NACK, '0, '0); n = n + 2'd1;
        end else if (poison_r) begin
          res_nxt[n] = mk(id_q, RSP_POISONED, '0, '0); n = n + 2'd1;
        end else if (rdw_r && count_r == '0) begin
          // rendezvous: data goes straight to the parked reader
          res_nxt[n] = mk(rdid_r, RSP_READ, addr_q, size_q); n = n + 2'd1;
          res_nxt[n] = mk(id_q, RSP_WRITE, '0, '0);          n = n + 2'd1;
          rdw_nxt    = 1'b0;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          // the writer that fills the last slot is held
          if (count_nxt != cap) begin
            res_nxt[n] = mk(id_q, RSP_WRITE, '0, '0); n = n + 2'd1;
          end
        end
      end
      CMD_READ: begin
        if (rdw_r) begin
          res_nxt[n] = mk(id_q, RSP_NACK, '0, '0); n = n + 2'd1;
        end else if (count_r == '0) begin
          if (poison_r) begin
            res_nxt[n] = mk(id_q, RSP_POISONED, '0, '0); n = n + 2'd1;
          end else begin
            rdw_nxt  = 1'b1;
            rdid_nxt = id_q;
          end
        end else begin
          res_nxt[n] = mk(id_q, RSP_READ, head_q.addr, head_q.size); n = n + 2'd1;
          if (count_r >= cap) begin
            res_nxt[n] = mk(tail_q.id, RSP_WRITE, '0, '0); n = n + 2'd1;
          end
          head_nxt  = (head_r == IW'(SLOTS - 1)) ? '0 : head_r + IW'(1);
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_POISON: begin
        if (poison_r) begin
          res_nxt[n] = mk(id_q, RSP_NACK, '0, '0); n = n + 2'd1;
        end else begin
          poison_nxt = 1'b1;
          if (rdw_r) begin
            res_nxt[n] = mk(rdid_r, RSP_POISONED, '0, '0); n = n + 2'd1;
          end
          if (count_r != '0 && count_r >= cap) begin
            // held writer is released and its tail entry dropped
            res_nxt[n] = mk(tail_q.id, RSP_POISONED, '0, '0); n = n + 2'd1;
            count_nxt  = count_r - CW'(1);
          end
          rdw_nxt    = 1'b0;
          res_nxt[n] = mk(id_q, RSP_POISON_OK, '0, '0); n = n + 2'd1;
        end
      end
      default: begin
        res_nxt[n] = mk(id_q, RSP_NACK, '0, '0); n = n + 2'd1;
      end
    endcase
  end

  assign stat.eval_cnt = n;
  assign stat.pending  = pend_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= SLOTS_RST;
      head_r   <= '0;
      count_r  <= '0;
      rdw_r    <= 1'b0;
      rdid_r   <= '0;
      poison_r <= 1'b0;
      pend_r   <= 2'd0;
    end else begin
      if (cfg_we && count_r == '0) slots_r <= cfg_wdata;
      if (cmd.eval) begin
        head_r   <= head_nxt;
        count_r  <= count_nxt;
        rdw_r    <= rdw_nxt;
        rdid_r   <= rdid_nxt;
        poison_r <= poison_nxt;
        pend_r   <= n;
      end else if (cmd.pop) begin
        pend_r   <= pend_r - 2'd1;
      end
    end
  end

  // memory, captured request and completion buffer
  always_ff @(posedge clk) begin
    if (mem_we && cmd.eval) begin
      mem[wr_slot] <= '{id: id_q, addr: addr_q, size: size_q};
    end
    if (cmd.capture) begin
      cmd_q  <= in_command;
      id_q   <= in_request_id;
      addr_q <= in_data_address;
      size_q <= in_data_size;
      head_q <= mem[head_r];
      tail_q <= mem[tl_slot];
    end
    if (cmd.eval) begin
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= res_nxt[i];
    end else if (cmd.pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) res_r[i] <= res_r[i+1];
    end
  end

  assign out_done_id      = res_r[0].id;
  assign out_response     = res_r[0].rsp;
  assign out_read_address = res_r[0].addr;
  assign out_read_size    = res_r[0].size;
  assign out_last         = (pend_r == 2'd1);

endmodule

/* hw/rtl/csp_channel_rendezvous_buffer.sv */
// Buffered one-to-one CSP channel with poison. A request word is taken only
// when the block is idle, and the head and tail entries of the pending-write
// memory are read at that same edge; the next cycle decides the outcome and
// updates the channel, and then the completion words go out in order on the
// result channel (one to three per request, last marks the final one), each
// held while out_ready is low. A read that parks or a write that fills the last
// slot produces nothing until a later request releases it. The capacity
// register is taken only while no write is buffered. The entry memory needs no
// clearing after reset.
module csp_channel_rendezvous_buffer #(
  parameter int SLOTS = csprb_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  csprb_req_if.sink                    in_req,
  csprb_rsp_if.source                  out_rsp,
  input  logic                         cfg_we,
  input  logic [csprb_pkg::CFG_W-1:0]  cfg_wdata
);
  import csprb_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  csprb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  csprb_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .in_command       (in_req.command),
    .in_request_id    (in_req.request_id),
    .in_data_address  (in_req.data_address),
    .in_data_size     (in_req.data_size),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_done_id      (out_rsp.done_id),
    .out_response     (out_rsp.response),
    .out_read_address (out_rsp.read_address),
    .out_read_size    (out_rsp.read_size),
    .out_last         (out_rsp.last)
  );

endmodule

/* hw/rtl/csprb_checker.sv */
// csprb_checker: port-level assertions on the channel buffer, bound to the top.
// Depends on csprb_pkg and csp_channel_rendezvous_buffer.
module csprb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [csprb_pkg::RSP_W-1:0] response,
  input logic [csprb_pkg::DATA_W-1:0] read_address,
  input logic [csprb_pkg::DATA_W-1:0] read_size,
  input logic                        last
);
  import csprb_pkg::*;

  // a stalled completion word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(response) && $stable(last))
    else $error("completion word changed under stall");

  // requests and completions never overlap
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while completion pending");

  // an accepted request blocks both sides for its evaluation cycle
  a_eval_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("no evaluation cycle after request");

  // only read completions carry data
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (response != RSP_READ) |-> (read_address == '0) && (read_size == '0))
    else $error("data on non-read completion");

endmodule

bind csp_channel_rendezvous_buffer csprb_checker u_csprb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .response     (out_rsp.response),
  .read_address (out_rsp.read_address),
  .read_size    (out_rsp.read_size),
  .last         (out_rsp.last)
);

/* test/csp_channel_rendezvous_buffer_tb.sv */
// csp_channel_rendezvous_buffer_tb: self-checking bench for the buffered CSP channel.
// A scoreboard class predicts the completion words; tasks drive requests and config.
// Depends on csprb_pkg, csprb_ifs and csp_channel_rendezvous_buffer.
module csp_channel_rendezvous_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csprb_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 300;
  localparam int PHASE_ITEMS = 15;

  typedef struct packed {
    result_t word;
    logic    last;
  } completion_t;

  class channel_scoreboard;
    logic [CFG_W-1:0]  cap_reg;
    entry_t            store [SLOTS];
    int unsigned       head;
    int unsigned       count;
    bit                reader_waiting;
    logic [ID_W-1:0]   reader_id;
    bit                poisoned;
    completion_t       pending_words[$];
    completion_t       batch[$];
    int unsigned       mismatches;

    function new();
      cap_reg = (CAP_RESET > SLOTS) ? CFG_W'(SLOTS) : CFG_W'(CAP_RESET);
      head = 0;
      count = 0;
      reader_waiting = 0;
      reader_id = '0;
      poisoned = 0;
      mismatches = 0;
    endfunction

    function int unsigned capacity();
      int unsigned c;
      c = 32'(cap_reg);
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    // Capacity only changes while nothing is buffered.
    function void set_capacity(logic [CFG_W-1:0] value);
      if (count == 0) cap_reg = value;
    endfunction

    function void add_word(logic [ID_W-1:0] id, rsp_t rsp, logic [DATA_W-1:0] addr,
                           logic [DATA_W-1:0] size);
      completion_t c;
      c.word.id = id;
      c.word.rsp = rsp;
      c.word.addr = addr;
      c.word.size = size;
      c.last = 1'b0;
      batch.push_back(c);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [DATA_W-1:0] addr, logic [DATA_W-1:0] size);
      int unsigned cap;
      int unsigned slot;
      int unsigned tail;
      cap = capacity();
      batch.delete();
      tail = (head + count + SLOTS - 1) % SLOTS;
      case (cmd)
        CMD_WRITE: begin
          if (count >= cap) begin
            add_word(id, RSP_NACK, '0, '0);
          end else if (poisoned) begin
            add_word(id, RSP_POISONED, '0, '0);
          end else if (reader_waiting && count == 0) begin
            // rendezvous: the word goes straight to the parked reader
            add_word(reader_id, RSP_READ, addr, size);
            reader_waiting = 0;
            add_word(id, RSP_WRITE, '0, '0);
          end else begin
            slot = (head + count) % SLOTS;
            store[slot[SIDX_W-1:0]].id = id;
            store[slot[SIDX_W-1:0]].addr = addr;
            store[slot[SIDX_W-1:0]].size = size;
            count++;
            if (count != cap) add_word(id, RSP_WRITE, '0, '0);
          end
        end
        CMD_READ: begin
          if (reader_waiting) begin
            add_word(id, RSP_NACK, '0, '0);
          end else if (count == 0) begin
            if (poisoned) begin
              add_word(id, RSP_POISONED, '0, '0);
            end else begin
              reader_waiting = 1;
              reader_id = id;
            end
          end else begin
            add_word(id, RSP_READ, store[head[SIDX_W-1:0]].addr,
                     store[head[SIDX_W-1:0]].size);
            // a full queue means the tail writer was held; release it
            if (count >= cap) add_word(store[tail[SIDX_W-1:0]].id, RSP_WRITE, '0, '0);
            head = (head + 1) % SLOTS;
            count--;
          end
        end
        CMD_POISON: begin
          if (poisoned) begin
            add_word(id, RSP_NACK, '0, '0);
          end else begin
            poisoned = 1;
            if (reader_waiting) add_word(reader_id, RSP_POISONED, '0, '0);
            if (count != 0 && count >= cap) begin
              add_word(store[tail[SIDX_W-1:0]].id, RSP_POISONED, '0, '0);
              count--;
            end
            reader_waiting = 0;
            add_word(id, RSP_POISON_OK, '0, '0);
          end
        end
        default: add_word(id, RSP_NACK, '0, '0);
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_words.push_back(batch[i]);
    endfunction

    function string describe(completion_t c);
      return $sformatf("id %0d rsp %0d addr %h size %h last %0b",
                       c.word.id, c.word.rsp, c.word.addr, c.word.size, c.last);
    endfunction

    function void check_completion(completion_t got);
      completion_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected completion word: %s", $realtime, describe(got));
        return;
      end
      want = pending_words.pop_front();
      if (got.word.id !== want.word.id || got.word.rsp !== want.word.rsp ||
          got.word.addr !== want.word.addr || got.word.size !== want.word.size ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: completion mismatch: expected %s, got %s", $realtime,
                   describe(want), describe(got));
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  csprb_req_if req_if ();
  csprb_rsp_if rsp_if ();

  channel_scoreboard board = new();

  int send_idle = 38;
  int recv_idle = 85;
  bit long_stall_req = 0;
  int stall_left = 0;

  csp_channel_rendezvous_buffer #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_rsp  (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: ready toggles at the falling edge; a long hold is counted here.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        stall_left = LONG_STALL;
        long_stall_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    completion_t got;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.word.id = rsp_if.done_id;
      got.word.rsp = rsp_t'(rsp_if.response);
      got.word.addr = rsp_if.read_address;
      got.word.size = rsp_if.read_size;
      got.last = rsp_if.last;
      board.check_completion(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] addr,
                               input logic [DATA_W-1:0] size);
    while ($urandom_range(0, 99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.request_id <= id;
    req_if.data_address <= addr;
    req_if.data_size <= size;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    board.note_request(cmd, id, addr, size);
    @(negedge clk);
  endtask

  task automatic send_random(input int poison_pct);
    int pick;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < poison_pct) cmd = CMD_POISON;
    else if (pick < poison_pct + 4) cmd = CMD_UNKNOWN;
    else if (pick < poison_pct + 52) cmd = CMD_WRITE;
    else cmd = CMD_READ;
    drive_request(cmd, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
  endtask

  // Parked reads or held writes give no word, so a settling wait follows the last one.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (board.pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_capacity(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Release a parked reader or empty the queue so the next capacity takes effect.
  task automatic drain_channel();
    while (board.reader_waiting || board.count != 0) begin
      if (board.reader_waiting)
        drive_request(CMD_WRITE, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
      else
        drive_request(CMD_READ, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
    end
    wait_idle();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int sidle, input int ridle,
                           input bit with_stall);
    drain_channel();
    write_capacity(cap);
    send_idle = sidle;
    recv_idle = ridle;
    if (with_stall) begin
      @(posedge clk);
      long_stall_req = 1;
      @(negedge clk);
    end
    repeat (PHASE_ITEMS) send_random(0);
  endtask

  task automatic directed_checks();
    int i;
    drive_request(CMD_WRITE, 8'd0, '0, '0);
    drive_request(CMD_READ, 8'd255, $urandom, $urandom);
    drive_request(CMD_READ, 8'd1, '0, '0);                    // parks
    drive_request(CMD_READ, 8'd2, '0, '0);                    // second reader
    drive_request(CMD_WRITE, 8'd3, '1, '1);                   // handed to reader
    for (i = 4; i < 8; i++)
      drive_request(CMD_WRITE, i[ID_W-1:0], $urandom, $urandom);  // last one is held
    drive_request(CMD_WRITE, 8'd8, $urandom, $urandom);       // full queue
    drive_request(CMD_UNKNOWN, 8'd9, $urandom, $urandom);
    write_capacity(3'd1);                                     // ignored, queue not empty
    for (i = 10; i < 14; i++)
      drive_request(CMD_READ, i[ID_W-1:0], '0, '0);
    write_capacity(3'd0);                                     // behaves as one slot
    drive_request(CMD_WRITE, 8'd20, $urandom, $urandom);      // held at once
    drive_request(CMD_WRITE, 8'd21, $urandom, $urandom);
    drive_request(CMD_READ, 8'd22, '0, '0);
    wait_idle();
  endtask

  task automatic poison_phase();
    int unsigned cap;
    int i;
    drain_channel();
    write_capacity(CFG_W'($urandom_range(1, SLOTS)));
    cap = board.capacity();
    for (i = 0; i < cap; i++)
      drive_request(CMD_WRITE, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
    // held writer
    drive_request(CMD_POISON, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
    // repeated
    drive_request(CMD_POISON, ID_W'($urandom_range(0, 255)), $urandom, $urandom);
    repeat (16) send_random(15);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.command <= '0;
    req_if.request_id <= '0;
    req_if.data_address <= '0;
    req_if.data_size <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_checks();
    run_phase(3'd7, 38, 85, 1'b0);
    run_phase(3'd1, 38, 85, 1'b0);
    run_phase(3'd2, 85, 38, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 7)), 85, 38, 1'b0);
    run_phase(3'd3, 0, 0, 1'b0);
    run_phase(3'd4, 0, 0, 1'b1);
    poison_phase();
    wait_idle();

    if (board.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
